### sv/crc16rc_pkg.sv
// shared types, constants and the crc byte update for the crc16 record checker
package crc16rc_pkg;

	localparam int IDX_W = 7;
	localparam int LEN_W = 7;
	localparam int CRC_W = 16;

	localparam logic [IDX_W-1:0] RECORD_BYTES = 7'd64;
	localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

	typedef enum logic [1:0] {
		REG_USE_GIVEN = 2'd0,
		REG_GIVEN_IDX = 2'd1,
		REG_MIN_LEN   = 2'd2,
		REG_MAX_LEN   = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_CRC_BAD = 2'd1,
		ST_LEN_BAD = 2'd2,
		ST_TRUNC   = 2'd3
	} status_t;

	typedef struct packed {
		logic             use_given;
		logic [LEN_W-1:0] given_idx;
		logic [LEN_W-1:0] min_len;
		logic [LEN_W-1:0] max_len;
	} cfg_t;

	// crc-16 ccitt update with one byte, msb first
	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
			input logic [7:0] b);
		logic [7:0]       x;
		logic [CRC_W-1:0] x16;
		x = crc[15:8] ^ b;
		x = x ^ (x >> 4);
		x16 = {8'h00, x};
		return {crc[7:0], 8'h00} ^ (x16 << 12) ^ (x16 << 5) ^ x16;
	endfunction

endpackage

### sv/crc16rc_cfg.sv
// configuration register file of the crc16 record checker
module crc16rc_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [1:0]                  wr_index,
	input  logic [crc16rc_pkg::LEN_W-1:0] wr_data,
	output crc16rc_pkg::cfg_t           cfg
);

	crc16rc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.use_given <= 1'b0;
			cfg_q.given_idx <= 7'd0;
			cfg_q.min_len   <= 7'd3;
			cfg_q.max_len   <= 7'd61;
		end else if (wr_en) begin
			unique case (crc16rc_pkg::reg_idx_t'(wr_index))
				crc16rc_pkg::REG_USE_GIVEN: cfg_q.use_given <= wr_data[0];
				crc16rc_pkg::REG_GIVEN_IDX: cfg_q.given_idx <= wr_data;
				crc16rc_pkg::REG_MIN_LEN:   cfg_q.min_len   <= wr_data;
				crc16rc_pkg::REG_MAX_LEN:   cfg_q.max_len   <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### sv/crc16_record_checker.sv
// top level of the crc16 record checker: byte scan, crc update and verdict
//
// Usage: record bytes enter on the input channel (data_byte, last_byte) with
// in_valid/in_ready, one transfer per byte. The byte marked last_byte closes
// the record and produces exactly one result transfer (status, crc_residue,
// terminator_index) on the output channel with out_valid/out_ready; other
// bytes produce none. Registers are written through the cfg channel
// (cfg_valid/cfg_ready, cfg_index, cfg_data), always ready; the user must write
// them only while idle, the block does not check it. A byte is registered in
// the input stage, then processed; a last byte's result is registered.
// Throughput: one byte per cycle unless a last byte meets a waiting result,
// set by the single crc update between the input stage register and the state
// and result registers. Reset clears the record state (crc 0xFFFF, index 0,
// scanning) and loads the register defaults. When the receiver stalls, bytes
// keep flowing until a last byte reaches the input stage while a result still
// waits; that byte and the input then hold until the pending result is taken.
module crc16_record_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [15:0] crc_residue,
	output logic [6:0]  terminator_index,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data
);

	typedef enum logic [1:0] {
		PH_SCAN   = 2'd0,
		PH_CRC_HI = 2'd1,
		PH_CRC_LO = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	crc16rc_pkg::cfg_t cfg;

	logic                               valid_s1;
	logic [7:0]                         data_s1;
	logic                               last_s1;

	logic [crc16rc_pkg::CRC_W-1:0]      crc_q;
	logic [crc16rc_pkg::IDX_W-1:0]      idx_q;
	phase_t                             phase_q;
	logic [crc16rc_pkg::LEN_W-1:0]      found_q;

	logic                               out_valid_q;
	crc16rc_pkg::status_t               status_q;
	logic [crc16rc_pkg::CRC_W-1:0]      residue_q;
	logic [crc16rc_pkg::LEN_W-1:0]      tidx_q;

	logic                               adv_s1;
	logic                               in_take;
	logic                               term;
	logic [crc16rc_pkg::CRC_W-1:0]      crc_upd;
	logic [crc16rc_pkg::CRC_W-1:0]      crc_n;
	logic [crc16rc_pkg::IDX_W-1:0]      idx_n;
	phase_t                             phase_n;
	logic [crc16rc_pkg::LEN_W-1:0]      found_n;
	logic                               known;
	logic [crc16rc_pkg::LEN_W-1:0]      tidx_n;
	crc16rc_pkg::status_t               status_n;
	logic [crc16rc_pkg::CRC_W-1:0]      residue_n;

	crc16rc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign cfg_ready = 1'b1;

	// input stage moves on unless a last byte meets a waiting result
	assign adv_s1   = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign in_take  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	assign crc_upd = crc16rc_pkg::crc_byte(crc_q, data_s1);
	assign term    = cfg.use_given ? (idx_q == cfg.given_idx) : (data_s1 == 8'h00);

	// record state after this byte
	always_comb begin
		crc_n   = crc_q;
		idx_n   = idx_q;
		phase_n = phase_q;
		found_n = found_q;
		if (idx_q < crc16rc_pkg::RECORD_BYTES) begin
			idx_n = idx_q + 7'd1;
			unique case (phase_q)
				PH_SCAN: begin
					if (term) begin
						found_n = idx_q;
						phase_n = PH_CRC_HI;
					end else begin
						crc_n = crc_upd;
					end
				end
				PH_CRC_HI: begin
					crc_n   = crc_upd;
					phase_n = PH_CRC_LO;
				end
				PH_CRC_LO: begin
					crc_n   = crc_upd;
					phase_n = PH_DONE;
				end
				PH_DONE: ;
				default: ;
			endcase
		end
	end

	// verdict for a record closed by this byte
	always_comb begin
		known     = cfg.use_given || (phase_n != PH_SCAN);
		tidx_n    = cfg.use_given ? cfg.given_idx : (known ? found_n : 7'd0);
		residue_n = '0;
		priority if (!known || tidx_n < cfg.min_len || tidx_n > cfg.max_len) begin
			status_n = crc16rc_pkg::ST_LEN_BAD;
		end else if (phase_n != PH_DONE) begin
			status_n = crc16rc_pkg::ST_TRUNC;
		end else begin
			residue_n = crc_n;
			status_n  = (crc_n == '0) ? crc16rc_pkg::ST_OK : crc16rc_pkg::ST_CRC_BAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= crc16rc_pkg::CRC_INIT;
			idx_q       <= '0;
			phase_q     <= PH_SCAN;
			found_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				if (last_s1) begin
					crc_q   <= crc16rc_pkg::CRC_INIT;
					idx_q   <= '0;
					phase_q <= PH_SCAN;
					found_q <= '0;
				end else begin
					crc_q   <= crc_n;
					idx_q   <= idx_n;
					phase_q <= phase_n;
					found_q <= found_n;
				end
			end
			if (adv_s1 && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			status_q  <= status_n;
			residue_q <= residue_n;
			tidx_q    <= tidx_n;
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = 2'(status_q);
	assign crc_residue      = residue_q;
	assign terminator_index = tidx_q;

endmodule
